// ===== hdl/fcd_pkg.sv =====
package fcd_pkg;

  localparam int MAX_OUTPUTS_DEF = 64;
  localparam int MAX_INPUTS_DEF  = 1024;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_ACT    = 2'd2;

  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd0;
  localparam logic [1:0] REG_INPUT_LENGTH = 2'd1;
  localparam logic [1:0] REG_BIAS_ENABLE  = 2'd2;
  localparam logic [1:0] REG_RELU_ENABLE  = 2'd3;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_COEF   = 2'd1,
    KIND_ACT    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        index;
    logic signed [7:0]  value;
    logic signed [31:0] bias_word;
    logic signed [31:0] dequant_word;
  } item_t;

  typedef struct packed {
    logic [6:0]  output_count;
    logic [10:0] input_length;
    logic        bias_enable;
    logic        relu_enable;
  } cfg_t;

endpackage

// ===== hdl/fcd_ram.sv =====
module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fcd_front.sv =====
module fcd_front #(
  parameter int MAX_OUTPUTS = fcd_pkg::MAX_OUTPUTS_DEF,
  parameter int MAX_INPUTS  = fcd_pkg::MAX_INPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_index,
  input  logic signed [7:0]  in_value,
  input  logic signed [31:0] in_bias_word,
  input  logic signed [31:0] in_dequant_word,
  output fcd_pkg::item_t     head,
  output logic               head_valid,
  input  logic               pop
);

  localparam int WDEPTH = MAX_OUTPUTS * MAX_INPUTS;

  fcd_pkg::item_t q_r [2];
  logic [1:0]     cnt_r;
  logic           wp_r;
  logic           rp_r;
  fcd_pkg::item_t item;
  logic           keep;
  logic           push;
  logic           do_pop;

  always_comb begin
    item.index        = in_index;
    item.value        = in_value;
    item.bias_word    = in_bias_word;
    item.dequant_word = in_dequant_word;
    item.kind         = fcd_pkg::KIND_ACT;
    keep              = 1'b0;
    unique case (in_mode)
      fcd_pkg::MODE_WEIGHT: begin
        item.kind = fcd_pkg::KIND_WEIGHT;
        keep      = 32'(in_index) < 32'(WDEPTH);
      end
      fcd_pkg::MODE_COEF: begin
        item.kind = fcd_pkg::KIND_COEF;
        keep      = 32'(in_index) < 32'(MAX_OUTPUTS);
      end
      fcd_pkg::MODE_ACT: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy && keep;
  assign head_valid = (cnt_r != 2'd0);
  assign do_pop     = pop && head_valid;
  assign head       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/fcd_back.sv =====
module fcd_back #(
  parameter int MAX_OUTPUTS = fcd_pkg::MAX_OUTPUTS_DEF,
  parameter int MAX_INPUTS  = fcd_pkg::MAX_INPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcd_pkg::cfg_t      cfg,
  input  fcd_pkg::item_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  output logic [5:0]         out_output_number,
  output logic signed [31:0] out_result_value,
  output logic               out_last_output
);

  localparam int WDEPTH = MAX_OUTPUTS * MAX_INPUTS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int OAW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int OCW    = $clog2(MAX_OUTPUTS + 1);
  localparam int POS_W  = $clog2(MAX_INPUTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ACC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                 state_r;
  logic [OAW-1:0]         o_r;
  logic [WAW-1:0]         waddr_r;
  logic [POS_W-1:0]       pos_r;
  logic signed [7:0]      act_r;
  logic [MAX_OUTPUTS-1:0] acc_vld_r;
  logic                   acc_vld_q_r;
  logic                   p1_vld_r;
  logic [OAW-1:0]         p1_o_r;
  logic                   fr_vld_r;
  logic [OAW-1:0]         fr_o_r;
  logic                   fr_last_r;
  logic                   f1_vld_r;
  logic [OAW-1:0]         f1_o_r;
  logic                   f1_last_r;
  logic signed [63:0]     prod_r;
  logic signed [31:0]     bias1_r;
  logic                   f2_vld_r;
  logic [OAW-1:0]         f2_o_r;
  logic                   f2_last_r;
  logic signed [49:0]     rnd_r;
  logic signed [31:0]     bias2_r;
  logic                   out_valid_r;
  logic [5:0]             out_num_r;
  logic signed [31:0]     out_val_r;
  logic                   out_last_r;

  logic [OCW-1:0]         n_eff;
  logic [POS_W-1:0]       len_eff;
  logic                   o_last;
  logic [31:0]            idx32;
  logic [31:0]            pos32;
  logic                   idle_take;
  logic signed [7:0]      w_q;
  logic signed [31:0]     acc_q;
  logic signed [31:0]     bias_q;
  logic signed [31:0]     mult_q;
  logic signed [31:0]     acc_cur;
  logic signed [15:0]     mac_prod;
  logic signed [31:0]     acc_new;
  logic signed [63:0]     prod_rnd;
  logic signed [50:0]     sum_w;
  logic signed [50:0]     act_w;

  always_comb begin
    if (cfg.output_count == 7'd0) begin
      n_eff = OCW'(1);
    end else if (32'(cfg.output_count) > 32'(MAX_OUTPUTS)) begin
      n_eff = OCW'(MAX_OUTPUTS);
    end else begin
      n_eff = OCW'(cfg.output_count);
    end
    if (cfg.input_length == 11'd0) begin
      len_eff = POS_W'(1);
    end else if (32'(cfg.input_length) > 32'(MAX_INPUTS)) begin
      len_eff = POS_W'(MAX_INPUTS);
    end else begin
      len_eff = POS_W'(cfg.input_length);
    end
  end

  assign o_last    = (32'(o_r) + 32'd1) == 32'(n_eff);
  assign idx32     = 32'(head.index);
  assign pos32     = 32'(pos_r);
  assign idle_take = (state_r == S_IDLE) && head_valid;
  assign pop       = idle_take;

  fcd_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (idle_take && head.kind == fcd_pkg::KIND_WEIGHT),
    .waddr (idx32[WAW-1:0]),
    .wdata (head.value),
    .raddr (waddr_r),
    .rdata (w_q)
  );

  fcd_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk   (clk),
    .we    (idle_take && head.kind == fcd_pkg::KIND_COEF),
    .waddr (idx32[OAW-1:0]),
    .wdata (head.bias_word),
    .raddr (o_r),
    .rdata (bias_q)
  );

  fcd_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_mult_ram (
    .clk   (clk),
    .we    (idle_take && head.kind == fcd_pkg::KIND_COEF),
    .waddr (idx32[OAW-1:0]),
    .wdata (head.dequant_word),
    .raddr (o_r),
    .rdata (mult_q)
  );

  assign acc_cur  = acc_vld_q_r ? acc_q : 32'sd0;
  assign mac_prod = act_r * w_q;
  assign acc_new  = acc_cur + 32'(mac_prod);

  fcd_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_acc_ram (
    .clk   (clk),
    .we    (p1_vld_r),
    .waddr (p1_o_r),
    .wdata (acc_new),
    .raddr (o_r),
    .rdata (acc_q)
  );

  assign prod_rnd = prod_r + 64'sd8192;
  assign sum_w    = 51'(rnd_r) + (cfg.bias_enable ? 51'(bias2_r) : 51'sd0);
  assign act_w    = (cfg.relu_enable && sum_w < 51'sd0) ? 51'sd0 : sum_w;

  always_ff @(posedge clk) begin
    acc_vld_q_r <= acc_vld_r[o_r];
    p1_o_r      <= o_r;
    fr_o_r      <= o_r;
    fr_last_r   <= o_last;
    f1_o_r      <= fr_o_r;
    f1_last_r   <= fr_last_r;
    prod_r      <= acc_cur * mult_q;
    bias1_r     <= bias_q;
    f2_o_r      <= f1_o_r;
    f2_last_r   <= f1_last_r;
    rnd_r       <= 50'(prod_rnd >>> 14);
    bias2_r     <= bias1_r;
    out_num_r   <= 6'(f2_o_r);
    out_last_r  <= f2_last_r;
    if (act_w > 51'sd2147483647) begin
      out_val_r <= 32'sh7FFFFFFF;
    end else if (act_w < -51'sd2147483648) begin
      out_val_r <= 32'sh80000000;
    end else begin
      out_val_r <= 32'(act_w);
    end
    if (idle_take && head.kind == fcd_pkg::KIND_ACT) begin
      act_r <= head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      o_r         <= '0;
      waddr_r     <= '0;
      pos_r       <= '0;
      acc_vld_r   <= '0;
      p1_vld_r    <= 1'b0;
      fr_vld_r    <= 1'b0;
      f1_vld_r    <= 1'b0;
      f2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_vld_r    <= 1'b0;
      fr_vld_r    <= 1'b0;
      f1_vld_r    <= fr_vld_r;
      f2_vld_r    <= f1_vld_r;
      out_valid_r <= f2_vld_r;
      if (p1_vld_r) begin
        acc_vld_r[p1_o_r] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (idle_take && head.kind == fcd_pkg::KIND_ACT) begin
            o_r     <= '0;
            waddr_r <= pos32[WAW-1:0];
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          p1_vld_r <= 1'b1;
          o_r      <= o_r + 1'b1;
          waddr_r  <= waddr_r + WAW'(MAX_INPUTS);
          if (o_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pos32 + 32'd1 >= 32'(len_eff)) begin
            pos_r   <= '0;
            o_r     <= '0;
            state_r <= S_FIN;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_FIN: begin
          fr_vld_r <= 1'b1;
          o_r      <= o_r + 1'b1;
          if (o_last) begin
            acc_vld_r <= '0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_output_number = out_num_r;
  assign out_result_value  = out_val_r;
  assign out_last_output   = out_last_r;

endmodule

// ===== hdl/int8_fully_connected_dequant_top.sv =====
// Weight and coefficient items retire from idle; an activation item makes one
// shared MAC pass over the accumulator memory, then a drain step. The last
// element of a vector adds one result read per output; each result passes
// the fr, f1, f2 and output registers, and results follow one per cycle.
// A two-item queue holds start requests; busy rises only when it is full.
// Synchronous reset clears control and accumulator valid bits, resets config.
module int8_fully_connected_dequant_top #(
  parameter int MAX_OUTPUTS = fcd_pkg::MAX_OUTPUTS_DEF,
  parameter int MAX_INPUTS  = fcd_pkg::MAX_INPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_index,
  input  logic signed [7:0]  in_value,
  input  logic signed [31:0] in_bias_word,
  input  logic signed [31:0] in_dequant_word,
  output logic               out_valid,
  output logic [5:0]         out_output_number,
  output logic signed [31:0] out_result_value,
  output logic               out_last_output,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fcd_pkg::cfg_t  cfg_r;
  fcd_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_count <= 7'd1;
      cfg_r.input_length <= 11'd1;
      cfg_r.bias_enable  <= 1'b0;
      cfg_r.relu_enable  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        fcd_pkg::REG_OUTPUT_COUNT: cfg_r.output_count <= pwdata[6:0];
        fcd_pkg::REG_INPUT_LENGTH: cfg_r.input_length <= pwdata[10:0];
        fcd_pkg::REG_BIAS_ENABLE:  cfg_r.bias_enable  <= pwdata[0];
        fcd_pkg::REG_RELU_ENABLE:  cfg_r.relu_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fcd_pkg::REG_OUTPUT_COUNT: prdata = 32'(cfg_r.output_count);
      fcd_pkg::REG_INPUT_LENGTH: prdata = 32'(cfg_r.input_length);
      fcd_pkg::REG_BIAS_ENABLE:  prdata = 32'(cfg_r.bias_enable);
      fcd_pkg::REG_RELU_ENABLE:  prdata = 32'(cfg_r.relu_enable);
      default:                   prdata = 32'd0;
    endcase
  end

  fcd_front #(.MAX_OUTPUTS(MAX_OUTPUTS), .MAX_INPUTS(MAX_INPUTS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_bias_word    (in_bias_word),
    .in_dequant_word (in_dequant_word),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop)
  );

  fcd_back #(.MAX_OUTPUTS(MAX_OUTPUTS), .MAX_INPUTS(MAX_INPUTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_output_number (out_output_number),
    .out_result_value  (out_result_value),
    .out_last_output   (out_last_output)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int NOUT = 64;
  localparam int NIN = 1024;
  localparam int LIMIT = 4000000;

  typedef struct {
    logic [5:0]         num;
    logic signed [31:0] val;
    logic               last;
  } fc_result_t;

  logic               clk;
  logic               rst_n;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = '0;
  logic [15:0]        in_index = '0;
  logic signed [7:0]  in_value = '0;
  logic signed [31:0] in_bias_word = '0;
  logic signed [31:0] in_dequant_word = '0;
  logic               out_valid;
  logic [5:0]         out_output_number;
  logic signed [31:0] out_result_value;
  logic               out_last_output;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int8_fully_connected_dequant_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_index(in_index), .in_value(in_value),
    .in_bias_word(in_bias_word), .in_dequant_word(in_dequant_word),
    .out_valid(out_valid), .out_output_number(out_output_number),
    .out_result_value(out_result_value), .out_last_output(out_last_output),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fcd_pkg::item_t     pending_items[$];
  fc_result_t         expected_results[$];
  logic signed [7:0]  weight_mem[int];
  logic signed [31:0] bias_mem[NOUT];
  logic signed [31:0] mult_mem[NOUT];
  logic [31:0]        acc_mem[NOUT];
  logic [10:0]        elem_pos;
  logic [6:0]         cfg_outputs;
  logic [10:0]        cfg_length;
  logic               cfg_bias;
  logic               cfg_relu;
  int                 error_count = 0;
  int                 result_count = 0;
  int                 vector_count = 0;
  int                 accepted_count = 0;
  int                 cycle_count = 0;
  int                 gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int eff_outputs();
    if (cfg_outputs == 0) return 1;
    if (cfg_outputs > NOUT) return NOUT;
    return int'(cfg_outputs);
  endfunction

  function automatic int eff_length();
    if (cfg_length == 0) return 1;
    if (cfg_length > NIN) return NIN;
    return int'(cfg_length);
  endfunction

  function automatic logic signed [31:0] dequantize(int o);
    logic signed [63:0] prod;
    logic signed [63:0] r;
    prod = $signed(acc_mem[o]) * mult_mem[o];
    r = (prod + 64'sd8192) >>> 14;
    if (cfg_bias) r = r + bias_mem[o];
    if (cfg_relu && r < 0) r = 0;
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    return r[31:0];
  endfunction

  task automatic predict_layer(input fcd_pkg::item_t it);
    int n;
    int w;
    fc_result_t res;
    n = eff_outputs();
    case (it.kind)
      fcd_pkg::KIND_WEIGHT: begin
        if (int'(it.index) < NOUT * NIN) weight_mem[int'(it.index)] = it.value;
      end
      fcd_pkg::KIND_COEF: begin
        if (int'(it.index) < NOUT) begin
          bias_mem[it.index[5:0]] = it.bias_word;
          mult_mem[it.index[5:0]] = it.dequant_word;
        end
      end
      fcd_pkg::KIND_ACT: begin
        if (int'(elem_pos) < NIN) begin
          for (int o = 0; o < n; o++) begin
            w = weight_mem.exists(o * NIN + int'(elem_pos))
                ? weight_mem[o * NIN + int'(elem_pos)] : 0;
            acc_mem[o] = acc_mem[o] + 32'(int'(it.value) * w);
          end
        end
        elem_pos = elem_pos + 11'd1;
        if (int'(elem_pos) >= eff_length()) begin
          for (int o = 0; o < n; o++) begin
            res.num = 6'(o);
            res.val = dequantize(o);
            res.last = (o == n - 1);
            expected_results.push_back(res);
          end
          for (int o = 0; o < NOUT; o++) acc_mem[o] = '0;
          elem_pos = '0;
          vector_count++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_layer(pending_items.pop_front());
        accepted_count <= accepted_count + 1;
      end
      if (start && !busy || gap_left > 0 || pending_items.size() == 0 || start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if ((start && busy) || (!start && pending_items.size() > 0)
                     || (start && !busy && pending_items.size() > 0)) begin
          if ($urandom_range(0, 3) == 0 && !(start && busy)) begin
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(0, 2);
            start <= 1'b0;
          end else begin
            start <= 1'b1;
            {in_mode, in_index, in_value, in_bias_word, in_dequant_word}
              <= (start && busy) ? {in_mode, in_index, in_value, in_bias_word,
                                    in_dequant_word} : pending_items[0];
          end
        end else begin
          start <= 1'b0;
        end
      end else if (pending_items.size() > 0) begin
        start <= 1'b1;
        {in_mode, in_index, in_value, in_bias_word, in_dequant_word} <= pending_items[0];
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_output_number), 32'd0);
      end else begin
        fc_result_t e;
        e = expected_results.pop_front();
        if (out_output_number !== e.num)
          report_mismatch("output_number", 32'(out_output_number), 32'(e.num));
        if (out_result_value !== e.val)
          report_mismatch("result_value", out_result_value, e.val);
        if (out_last_output !== e.last)
          report_mismatch("last_output", 32'(out_last_output), 32'(e.last));
        result_count++;
      end
    end
  end

  task automatic reg_write(input logic [1:0] r, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      fcd_pkg::REG_OUTPUT_COUNT: cfg_outputs = v[6:0];
      fcd_pkg::REG_INPUT_LENGTH: cfg_length = v[10:0];
      fcd_pkg::REG_BIAS_ENABLE:  cfg_bias = v[0];
      fcd_pkg::REG_RELU_ENABLE:  cfg_relu = v[0];
      default: ;
    endcase
  endtask

  function automatic fcd_pkg::item_t make_item(fcd_pkg::kind_t k, logic [31:0] idx,
                                               logic [31:0] v, logic [31:0] b,
                                               logic [31:0] m);
    fcd_pkg::item_t it;
    it.kind = k; it.index = idx[15:0]; it.value = v[7:0]; it.bias_word = b;
    it.dequant_word = m;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_mult();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_layer(input int n, input int len);
    for (int o = 0; o < n; o++) begin
      pending_items.push_back(make_item(fcd_pkg::KIND_COEF, o, $urandom, $urandom,
                                        rand_mult()));
      for (int e = 0; e < len; e++)
        pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT, o * NIN + e, $urandom,
                                          $urandom, $urandom));
    end
  endtask

  task automatic push_vector(input int len);
    for (int e = 0; e < len; e++)
      pending_items.push_back(make_item(fcd_pkg::KIND_ACT, $urandom, $urandom, $urandom,
                                        $urandom));
  endtask

  initial begin
    int n;
    int len;
    fcd_pkg::item_t it;
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0;
    pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_outputs = 7'd1; cfg_length = 11'd1; cfg_bias = 1'b0; cfg_relu = 1'b0;
    elem_pos = '0;
    for (int o = 0; o < NOUT; o++) begin
      acc_mem[o] = '0; bias_mem[o] = '0; mult_mem[o] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored writes, unused mode, saturation
    reg_write(fcd_pkg::REG_OUTPUT_COUNT, 32'd2);
    reg_write(fcd_pkg::REG_INPUT_LENGTH, 32'd2);
    reg_write(fcd_pkg::REG_BIAS_ENABLE, 32'd1);
    reg_write(fcd_pkg::REG_RELU_ENABLE, 32'd0);
    pending_items.push_back(make_item(fcd_pkg::KIND_COEF, 0, 0, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF));
    pending_items.push_back(make_item(fcd_pkg::KIND_COEF, 1, 0, 32'h8000_0000,
                                      32'h8000_0000));
    pending_items.push_back(make_item(fcd_pkg::KIND_COEF, 'hFFFF, 0, 'h1234, 'h5678));
    pending_items.push_back(make_item(fcd_pkg::KIND_COEF, 64, 0, 'h1234, 'h5678));
    pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT, 0, 'h80, 0, 0));
    pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT, 1, 'h7F, 0, 0));
    pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT, 1024, 'h7F, 0, 0));
    pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT, 1025, 'h80, 0, 0));
    pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT, 'hFFFF, 'h01, 32'hFFFF_FFFF, 0));
    it = make_item(fcd_pkg::KIND_ACT, 0, 'h80, 0, 0);
    it.kind = fcd_pkg::kind_t'(2'd3);
    pending_items.push_back(it);
    pending_items.push_back(make_item(fcd_pkg::KIND_ACT, 'hFFFF, 'h80, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF));
    pending_items.push_back(make_item(fcd_pkg::KIND_ACT, 0, 'h7F, 0, 0));
    pending_items.push_back(make_item(fcd_pkg::KIND_ACT, 0, 'h80, 0, 0));
    pending_items.push_back(make_item(fcd_pkg::KIND_ACT, 0, 'h80, 0, 0));
    drain();
    reg_write(fcd_pkg::REG_RELU_ENABLE, 32'd1);
    reg_write(fcd_pkg::REG_BIAS_ENABLE, 32'd0);
    push_vector(2);
    drain();

    // register out of range: zero acts as one, above max acts as max
    reg_write(fcd_pkg::REG_OUTPUT_COUNT, 32'd0);
    reg_write(fcd_pkg::REG_INPUT_LENGTH, 32'd0);
    push_vector(1);
    drain();

    reg_write(fcd_pkg::REG_OUTPUT_COUNT, 32'd127);
    reg_write(fcd_pkg::REG_INPUT_LENGTH, 32'd1);
    load_layer(64, 1);
    push_vector(1);
    drain();

    // random phases with small layers
    for (int ph = 0; ph < 6; ph++) begin
      n = $urandom_range(1, 6);
      len = $urandom_range(1, 4);
      reg_write(fcd_pkg::REG_OUTPUT_COUNT, n);
      reg_write(fcd_pkg::REG_INPUT_LENGTH, len);
      reg_write(fcd_pkg::REG_BIAS_ENABLE, $urandom_range(0, 1));
      reg_write(fcd_pkg::REG_RELU_ENABLE, $urandom_range(0, 1));
      load_layer(n, len);
      repeat ($urandom_range(1, 4)) begin
        push_vector(len);
        if ($urandom_range(0, 3) == 0)
          pending_items.push_back(make_item(fcd_pkg::KIND_WEIGHT,
                                            n * NIN + $urandom_range(0, 5),
                                            $urandom, $urandom, $urandom));
      end
      drain();
    end

    $display("accepted %0d items, checked %0d results over %0d vectors",
             accepted_count, result_count, vector_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
